// File: rtl/ltc_pkg.sv
// Shared constants, type codes and keyword matching for the literal type classifier.
// No dependencies.
package ltc_pkg;

	typedef enum logic [2:0] {
		TC_BOOL   = 3'd0,
		TC_INT    = 3'd1,
		TC_FLOAT  = 3'd2,
		TC_STRING = 3'd3,
		TC_LIST   = 3'd4,
		TC_NONE   = 3'd5,
		TC_EXPR   = 3'd6,
		TC_UNREC  = 3'd7
	} type_code_t;

	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_POINT  = 8'h2e;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [2:0] POS_MAX = 3'd6;

	// alive_q / alive_n bit positions
	localparam int KW_TRUE  = 0;
	localparam int KW_FALSE = 1;
	localparam int KW_NONE  = 2;

	typedef logic [2:0] kw_t;

	// per-keyword match of byte c at position pos
	function automatic kw_t kw_match(input logic [2:0] pos, input logic [7:0] c);
		kw_t m;
		m = '0;
		unique case (pos)
			3'd0: begin
				m[KW_TRUE]  = (c == "t");
				m[KW_FALSE] = (c == "f");
				m[KW_NONE]  = (c == "N");
			end
			3'd1: begin
				m[KW_TRUE]  = (c == "r");
				m[KW_FALSE] = (c == "a");
				m[KW_NONE]  = (c == "o");
			end
			3'd2: begin
				m[KW_TRUE]  = (c == "u");
				m[KW_FALSE] = (c == "l");
				m[KW_NONE]  = (c == "n");
			end
			3'd3: begin
				m[KW_TRUE]  = (c == "e");
				m[KW_FALSE] = (c == "s");
				m[KW_NONE]  = (c == "e");
			end
			3'd4: begin
				m[KW_FALSE] = (c == "e");
			end
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

// File: rtl/ltc_track.sv
// Running token state and type decision for the literal type classifier.
// Depends on ltc_pkg.
module ltc_track import ltc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] char_s1,
	input  logic       final_s1,
	output type_code_t code
);

	logic [2:0] pos_q;
	logic [7:0] first_q;
	logic       digits_only_q;
	logic       digits_or_points_q;
	logic       point_seen_q;
	kw_t        alive_q;

	logic [7:0] first_n;
	logic       skip;
	logic       digit;
	logic       is_point;
	logic       digits_only_n;
	logic       digits_or_points_n;
	logic       point_seen_n;
	kw_t        alive_n;
	logic       kw_true;
	logic       kw_false;
	logic       kw_none;

	always_comb begin
		first_n            = (pos_q == 3'd0) ? char_s1 : first_q;
		skip               = (pos_q == 3'd0) && (char_s1 == CH_MINUS);
		digit              = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
		is_point           = (char_s1 == CH_POINT);
		digits_only_n      = digits_only_q & (skip | digit);
		digits_or_points_n = digits_or_points_q & (skip | digit | is_point);
		point_seen_n       = point_seen_q | (!skip && !digit && is_point);
		alive_n            = alive_q & kw_match(pos_q, char_s1);
		kw_true            = alive_n[KW_TRUE] && (pos_q == 3'd3);
		kw_false           = alive_n[KW_FALSE] && (pos_q == 3'd4);
		kw_none            = alive_n[KW_NONE] && (pos_q == 3'd3);

		if (kw_true || kw_false) begin
			code = TC_BOOL;
		end else if (digits_only_n) begin
			code = TC_INT;
		end else if (digits_or_points_n && point_seen_n) begin
			code = TC_FLOAT;
		end else if (first_n == CH_QUOTE && char_s1 == CH_QUOTE) begin
			code = TC_STRING;
		end else if (first_n == CH_LPAREN && char_s1 == CH_RPAREN) begin
			code = TC_LIST;
		end else if (kw_none) begin
			code = TC_NONE;
		end else if (first_n == CH_DOLLAR) begin
			code = TC_EXPR;
		end else begin
			code = TC_UNREC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q              <= '0;
			first_q            <= '0;
			digits_only_q      <= 1'b1;
			digits_or_points_q <= 1'b1;
			point_seen_q       <= 1'b0;
			alive_q            <= '1;
		end else if (advance) begin
			if (final_s1) begin
				pos_q              <= '0;
				first_q            <= '0;
				digits_only_q      <= 1'b1;
				digits_or_points_q <= 1'b1;
				point_seen_q       <= 1'b0;
				alive_q            <= '1;
			end else begin
				pos_q              <= (pos_q < POS_MAX) ? pos_q + 3'd1 : POS_MAX;
				first_q            <= first_n;
				digits_only_q      <= digits_only_n;
				digits_or_points_q <= digits_or_points_n;
				point_seen_q       <= point_seen_n;
				alive_q            <= alive_n;
			end
		end
	end

endmodule

// File: rtl/literal_type_classifier.sv
// The type code is registered: it is valid from the edge at which the final beat leaves the input
// register. Throughput: one beat per cycle, but a final beat waits while a result is not taken.
// A result waiting in the output register does not stop non-final beats.
// Reset (arst_n, asynchronous, active low) empties both registers and clears token state.
// Depends on ltc_pkg and ltc_track.
module literal_type_classifier import ltc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	input  logic       is_final,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] type_code
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       final_s1;
	logic       advance;
	type_code_t code;
	logic       out_valid_q;
	type_code_t code_q;

	// a final beat needs room in the output register
	assign advance  = valid_s1 && (!final_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1  <= char_in;
			final_s1 <= is_final;
		end
	end

	ltc_track u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.char_s1  (char_s1),
		.final_s1 (final_s1),
		.code     (code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && final_s1) begin
			code_q <= code;
		end
	end

	assign out_valid = out_valid_q;
	assign type_code = code_q;

endmodule

// File: bench/literal_type_classifier_tb.sv
`timescale 1ns / 100ps
// Testbench for literal_type_classifier: streams tokens one byte per beat and checks each type code
// against a cycle-free predictor of the token classification. Depends on ltc_pkg and the RTL.
module literal_type_classifier_tb;
	import ltc_pkg::*;

	typedef logic [7:0] byte_q_t[$];
	typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

	localparam int RANDOM_CHARS = 1250;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 10;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] char_in;
	logic       is_final;
	logic       out_valid;
	logic       out_ready;
	logic [2:0] type_code;

	type_code_t expected_codes[$];
	int         failures;
	int         chars_sent;
	int         burst_left;
	int         hold_reqs;
	int         hold_seen;
	int         hold_left;
	int         stall_cycles;
	rx_mode_t   rx_mode;
	int         rx_mode_left;
	int         rx_phase;

	// running token state
	logic [2:0] tok_pos;
	logic [7:0] tok_first;
	bit         all_digits;
	bit         digits_points;
	bit         saw_point;
	logic [2:0] kw_live;

	literal_type_classifier u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_in   (char_in),
		.is_final  (is_final),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.type_code (type_code)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_token();
		tok_pos       = '0;
		tok_first     = '0;
		all_digits    = 1'b1;
		digits_points = 1'b1;
		saw_point     = 1'b0;
		kw_live       = '1;
	endfunction

	function automatic bit kw_byte_ok(string word, logic [2:0] pos, logic [7:0] c);
		return pos < word.len() && word[pos] == c;
	endfunction

	task automatic classify_beat(input logic [7:0] c, input bit fin);
		logic [7:0] first;
		logic [2:0] live;
		bit         is_digit;
		type_code_t code;
		first    = (tok_pos == 0) ? c : tok_first;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		live     = kw_live;
		if (!(tok_pos == 0 && c == CH_MINUS) && !is_digit) begin
			all_digits = 1'b0;
			if (c == CH_POINT)
				saw_point = 1'b1;
			else
				digits_points = 1'b0;
		end
		if (!kw_byte_ok("true", tok_pos, c))
			live[KW_TRUE] = 1'b0;
		if (!kw_byte_ok("false", tok_pos, c))
			live[KW_FALSE] = 1'b0;
		if (!kw_byte_ok("None", tok_pos, c))
			live[KW_NONE] = 1'b0;
		if (!fin) begin
			tok_first = first;
			kw_live   = live;
			if (tok_pos != POS_MAX)
				tok_pos = tok_pos + 3'd1;
		end else begin
			if ((live[KW_TRUE] && tok_pos == 3'd3) || (live[KW_FALSE] && tok_pos == 3'd4))
				code = TC_BOOL;
			else if (all_digits)
				code = TC_INT;
			else if (digits_points && saw_point)
				code = TC_FLOAT;
			else if (first == CH_QUOTE && c == CH_QUOTE)
				code = TC_STRING;
			else if (first == CH_LPAREN && c == CH_RPAREN)
				code = TC_LIST;
			else if (live[KW_NONE] && tok_pos == 3'd3)
				code = TC_NONE;
			else if (first == CH_DOLLAR)
				code = TC_EXPR;
			else
				code = TC_UNREC;
			expected_codes.push_back(code);
			clear_token();
		end
	endtask

	function automatic void note_failure(string what, logic [2:0] want, logic [2:0] got);
		failures++;
		if (failures <= 10)
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
	endfunction

	always @(posedge clk) begin
		type_code_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				classify_beat(char_in, is_final);
			if (out_valid && out_ready) begin
				if (expected_codes.size() == 0) begin
					note_failure("unexpected result", 3'bx, type_code);
				end else begin
					want = expected_codes.pop_front();
					if (type_code !== want)
						note_failure("type_code", want, type_code);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_seen != hold_reqs) begin
			hold_seen++;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(20, 200);
			end
			rx_mode_left--;
			rx_phase++;
			case (rx_mode)
				RX_OPEN:    out_ready <= 1'b1;
				RX_RANDOM:  out_ready <= 1'($urandom_range(0, 1));
				RX_PATTERN: out_ready <= (rx_phase % 7) < 3;
				default:    out_ready <= ($urandom_range(0, 9) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic sender_pause();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		gap = $urandom_range(1, 8);
		in_valid <= 1'b0;
		repeat (gap) @(posedge clk);
		burst_left = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 24);
	endtask

	task automatic send_bytes(input byte_q_t tok);
		for (int i = 0; i < tok.size(); i++) begin
			char_in  <= tok[i];
			is_final <= (i == tok.size() - 1);
			in_valid <= 1'b1;
			do @(posedge clk); while (!in_ready);
			chars_sent++;
			sender_pause();
		end
	endtask

	task automatic send_text(input string s);
		byte_q_t tok;
		for (int i = 0; i < s.len(); i++)
			tok.push_back(s[i]);
		send_bytes(tok);
	endtask

	task automatic test_keywords();
		send_text("true");
		send_text("false");
		send_text("None");
	endtask

	task automatic test_numbers();
		// lone minus, a float, then the bytes either side of the digit range
		send_text("-");
		send_text("1.2");
		send_text("/:");
	endtask

	task automatic test_delimiters();
		send_text("\"");
		send_text("(x)");
		send_text("$");
		send_bytes('{8'h00, 8'hff});
	endtask

	task automatic test_output_hold();
		hold_reqs++;
		burst_left = 1000;
		repeat (12) send_text("7");
		send_text("falsehood");
		repeat (12) send_text("$");
		burst_left = 0;
	endtask

	task automatic test_random_tokens();
		byte_q_t tok;
		string   kw;
		int      kind;
		int      len;
		int      at;
		while (chars_sent < RANDOM_CHARS) begin
			tok.delete();
			kind = $urandom_range(0, 9);
			len  = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
			case (kind)
				0, 1: begin
					case ($urandom_range(0, 2))
						0:       kw = "true";
						1:       kw = "false";
						default: kw = "None";
					endcase
					for (int i = 0; i < kw.len(); i++)
						tok.push_back(kw[i]);
					case ($urandom_range(0, 3))
						1: void'(tok.pop_back());
						2: tok.push_back(8'(8'h61 + $urandom_range(0, 25)));
						3: begin
							at = $urandom_range(0, tok.size() - 1);
							tok[at] = tok[at] ^ 8'h20;
						end
						default: ;
					endcase
				end
				2: begin
					if ($urandom_range(0, 2) == 0)
						tok.push_back(CH_MINUS);
					repeat (len) tok.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
				end
				3: begin
					repeat (len) tok.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
					repeat ($urandom_range(1, 2)) tok.insert($urandom_range(0, tok.size()), CH_POINT);
					if ($urandom_range(0, 3) == 0)
						tok.push_front(CH_MINUS);
				end
				4: begin
					tok.push_back(CH_QUOTE);
					repeat (len) tok.push_back(8'($urandom_range(8'h20, 8'h7e)));
					tok.push_back(CH_QUOTE);
				end
				5: begin
					tok.push_back(CH_LPAREN);
					repeat (len) tok.push_back(8'($urandom_range(8'h20, 8'h7e)));
					tok.push_back(CH_RPAREN);
				end
				6: begin
					tok.push_back(CH_DOLLAR);
					repeat (len) tok.push_back(8'($urandom_range(8'h20, 8'h7e)));
				end
				7: begin
					repeat (len + 1) tok.push_back(8'($urandom_range(0, 255)));
				end
				default: begin
					// digits after a quote, paren or digit and before a quote or paren, with one byte overwritten by a random value
					case ($urandom_range(0, 2))
						0: tok.push_back(CH_QUOTE);
						1: tok.push_back(CH_LPAREN);
						default: tok.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
					endcase
					repeat (len + 1) tok.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
					tok.push_back($urandom_range(0, 1) ? CH_QUOTE : CH_RPAREN);
					at = $urandom_range(0, tok.size() - 1);
					tok[at] = 8'($urandom_range(0, 255));
				end
			endcase
			if (tok.size() == 0)
				tok.push_back(8'($urandom_range(0, 255)));
			send_bytes(tok);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		char_in   = '0;
		is_final  = 1'b0;
		out_ready = 1'b0;
		clear_token();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_keywords();
		test_numbers();
		test_delimiters();
		test_output_hold();
		test_random_tokens();

		in_valid <= 1'b0;
		while (expected_codes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: filelist.f
rtl/ltc_pkg.sv
rtl/ltc_track.sv
rtl/literal_type_classifier.sv
bench/literal_type_classifier_tb.sv
